// File: hdl/field_error_statistics_core_macros.svh
// Assertion macros for the field error statistics controller (fes_ctrl).
// Checks vanish when SYNTHESIS is defined.
`ifndef FIELD_ERROR_STATISTICS_CORE_MACROS_SVH
`define FIELD_ERROR_STATISTICS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check held off while reset is high
`define FES_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs through reset
`define FES_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FES_ASSERT(label, clk, rst, prop, msg)

`define FES_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: hdl/fes_pkg.sv
package fes_pkg;

   // Field widths
   localparam int VAL_W     = 32;
   localparam int THR_W     = 31;
   localparam int IDX_W     = 24;
   localparam int FRAC_W    = 16;
   localparam int DVD_W     = VAL_W + FRAC_W;
   localparam int CSR_IDX_W = 1;

   // Restoring divider: one quotient bit per step
   localparam int DIV_STEPS = DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int DEFAULT_MAX_POINTS = 16777216;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ABS_THRESHOLD   = 1'b0,
      CSR_OUTPUT_ABSOLUTE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic calc;
      logic div_step;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic fallback;
   } sts_type;

endpackage

// File: hdl/fes_ctrl.sv
`include "field_error_statistics_core_macros.svh"

module fes_ctrl import fes_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   div_last;

   assign div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = sts.fallback ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and commands
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      div_cnt_in   = div_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CALC: begin
            cmd.calc   = 1'b1;
            div_cnt_in = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
         end
         ST_FINISH: begin
            cmd.commit = !out_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   // Output register occupancy
   always_comb begin
      if (cmd.commit) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `FES_ASSERT(a_accept_to_calc, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_CALC), "accepted item did not enter calc")
   `FES_ASSERT(a_commit_free, clock, reset, cmd.commit |-> (!out_valid_ff || rsp_ready), "result written over a pending one")
   `FES_ASSERT(a_commit_shows, clock, reset, cmd.commit |=> rsp_valid, "committed result not presented")
   `FES_ASSERT(a_div_bound, clock, reset, (state_ff == ST_DIV) |-> (div_cnt_ff < DIV_CNT_W'(DIV_STEPS)), "divider step count out of range")
   `FES_ASSERT_ALWAYS(a_no_rsp_in_reset, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

// File: hdl/fes_dp.sv
module fes_dp import fes_pkg::*; #(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_data,
   input  logic signed [VAL_W-1:0] req_value_a,
   input  logic signed [VAL_W-1:0] req_value_b,
   input  logic                    req_last_element,
   output logic [VAL_W-1:0]        rsp_element_error,
   output logic                    rsp_field_done,
   output logic [VAL_W-1:0]        rsp_min_relative,
   output logic [VAL_W-1:0]        rsp_max_relative,
   output logic [IDX_W-1:0]        rsp_max_relative_index,
   output logic [VAL_W-1:0]        rsp_min_absolute,
   output logic [VAL_W-1:0]        rsp_max_absolute,
   output logic [IDX_W-1:0]        rsp_max_absolute_index
);

   // Index saturates at the smaller of MAX_POINTS-1 and the index field range
   localparam logic [IDX_W-1:0] COUNT_CAP =
      (longint'(MAX_POINTS) - 1 < (longint'(1) << IDX_W) - 1) ?
      IDX_W'(MAX_POINTS - 1) : {IDX_W{1'b1}};

   // Configuration
   logic [THR_W-1:0] thr_ff;
   logic             out_abs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= '0;
         out_abs_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ABS_THRESHOLD:   thr_ff     <= csr_data[THR_W-1:0];
            CSR_OUTPUT_ABSOLUTE: out_abs_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Input capture
   logic [VAL_W-1:0] a_ff, b_ff;
   logic             last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= req_value_a;
         b_ff    <= req_value_b;
         last_ff <= req_last_element;
      end
   end

   // Magnitudes, absolute error, fallback test
   logic [VAL_W-1:0] mag_a, mag_b, abse, den;
   logic [VAL_W:0]   diff;
   logic             fallback;

   always_comb begin
      mag_a    = a_ff[VAL_W-1] ? (~a_ff + 1'b1) : a_ff;
      mag_b    = b_ff[VAL_W-1] ? (~b_ff + 1'b1) : b_ff;
      diff     = {a_ff[VAL_W-1], a_ff} - {b_ff[VAL_W-1], b_ff};
      abse     = diff[VAL_W] ? VAL_W'(~diff + 1'b1) : diff[VAL_W-1:0];
      fallback = (mag_a <= {1'b0, thr_ff}) || (mag_b <= {1'b0, thr_ff});
      den      = (mag_a > mag_b) ? mag_a : mag_b;
   end

   assign sts.fallback = fallback;

   // Restoring divider; dividend register fills with quotient bits
   logic [VAL_W-1:0] abse_ff, den_ff, rem_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic             fallback_ff;
   logic [VAL_W:0]   trial, trial_sub;
   logic             qbit;

   always_comb begin
      trial     = {rem_ff, dvd_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      qbit      = (trial >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         abse_ff     <= abse;
         den_ff      <= den;
         fallback_ff <= fallback;
         rem_ff      <= '0;
         dvd_ff      <= {abse, {FRAC_W{1'b0}}};
      end else if (cmd.div_step) begin
         rem_ff <= qbit ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], qbit};
      end
   end

   // Running statistics
   logic [IDX_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] min_rel_ff, min_rel_in, max_rel_ff, max_rel_in;
   logic [VAL_W-1:0] min_abs_ff, min_abs_in, max_abs_ff, max_abs_in;
   logic [IDX_W-1:0] max_rel_idx_ff, max_rel_idx_in, max_abs_idx_ff, max_abs_idx_in;
   logic [VAL_W-1:0] rele;
   logic             first;

   always_comb begin
      rele  = fallback_ff ? abse_ff : dvd_ff[VAL_W-1:0];
      first = (count_ff == '0);
      if (first) begin
         min_rel_in     = rele;
         max_rel_in     = rele;
         max_rel_idx_in = '0;
         min_abs_in     = abse_ff;
         max_abs_in     = abse_ff;
         max_abs_idx_in = '0;
      end else begin
         min_rel_in     = (rele < min_rel_ff) ? rele : min_rel_ff;
         max_rel_in     = max_rel_ff;
         max_rel_idx_in = max_rel_idx_ff;
         if (rele > max_rel_ff) begin
            max_rel_in     = rele;
            max_rel_idx_in = count_ff;
         end
         min_abs_in     = (abse_ff < min_abs_ff) ? abse_ff : min_abs_ff;
         max_abs_in     = max_abs_ff;
         max_abs_idx_in = max_abs_idx_ff;
         if (abse_ff > max_abs_ff) begin
            max_abs_in     = abse_ff;
            max_abs_idx_in = count_ff;
         end
      end
      count_in = (count_ff < COUNT_CAP) ? count_ff + 1'b1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         min_rel_ff     <= '0;
         max_rel_ff     <= '0;
         max_rel_idx_ff <= '0;
         min_abs_ff     <= '0;
         max_abs_ff     <= '0;
         max_abs_idx_ff <= '0;
      end else if (cmd.commit) begin
         if (last_ff) begin
            count_ff       <= '0;
            min_rel_ff     <= '0;
            max_rel_ff     <= '0;
            max_rel_idx_ff <= '0;
            min_abs_ff     <= '0;
            max_abs_ff     <= '0;
            max_abs_idx_ff <= '0;
         end else begin
            count_ff       <= count_in;
            min_rel_ff     <= min_rel_in;
            max_rel_ff     <= max_rel_in;
            max_rel_idx_ff <= max_rel_idx_in;
            min_abs_ff     <= min_abs_in;
            max_abs_ff     <= max_abs_in;
            max_abs_idx_ff <= max_abs_idx_in;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_element_error      <= out_abs_ff ? abse_ff : rele;
         rsp_field_done         <= last_ff;
         rsp_min_relative       <= last_ff ? min_rel_in : '0;
         rsp_max_relative       <= last_ff ? max_rel_in : '0;
         rsp_max_relative_index <= last_ff ? max_rel_idx_in : '0;
         rsp_min_absolute       <= last_ff ? min_abs_in : '0;
         rsp_max_absolute       <= last_ff ? max_abs_in : '0;
         rsp_max_absolute_index <= last_ff ? max_abs_idx_in : '0;
      end
   end

endmodule

// File: hdl/field_error_statistics_core.sv
// Field error statistics core.
// Input channel req_*: one pair of signed Q15.16 samples per transfer, with
// req_last_element marking the final pair of a field. Result channel rsp_*:
// one result per input item, in order: the absolute or relative error that
// the output_absolute register selects, plus on the last element the min and
// max of both errors and the first index of each maximum (zero otherwise).
// Configuration channel csr_*: index 0 is abs_threshold, index 1 is
// output_absolute; always ready, write only while no item is in flight.
// Sequence: accept; magnitudes and the fallback test; the bit-serial restoring
// divider over the 48-bit dividend, which retires one quotient bit per cycle;
// then the statistics update and the output register load. The divider is
// skipped when the relative error falls back to the absolute error. Items are
// processed one at a time.
// A finished result waits in the output register; the next item is accepted
// and worked on meanwhile, and only its final step holds while rsp_ready is low.
// Reset (synchronous) clears the configuration registers, the running statistics
// and the element count; no result is pending afterwards.
module field_error_statistics_core import fes_pkg::*; #(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_value_a,
   input  logic signed [VAL_W-1:0] req_value_b,
   input  logic                    req_last_element,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [VAL_W-1:0]        rsp_element_error,
   output logic                    rsp_field_done,
   output logic [VAL_W-1:0]        rsp_min_relative,
   output logic [VAL_W-1:0]        rsp_max_relative,
   output logic [IDX_W-1:0]        rsp_max_relative_index,
   output logic [VAL_W-1:0]        rsp_min_absolute,
   output logic [VAL_W-1:0]        rsp_max_absolute,
   output logic [IDX_W-1:0]        rsp_max_absolute_index,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   fes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fes_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_value_a            (req_value_a),
      .req_value_b            (req_value_b),
      .req_last_element       (req_last_element),
      .rsp_element_error      (rsp_element_error),
      .rsp_field_done         (rsp_field_done),
      .rsp_min_relative       (rsp_min_relative),
      .rsp_max_relative       (rsp_max_relative),
      .rsp_max_relative_index (rsp_max_relative_index),
      .rsp_min_absolute       (rsp_min_absolute),
      .rsp_max_absolute       (rsp_max_absolute),
      .rsp_max_absolute_index (rsp_max_absolute_index)
   );

endmodule

// File: tb/field_error_statistics_checker.sv
// Watches the three channels of the field error statistics core, predicts each
// result from the accepted pairs and compares it with what the block returns.
module field_error_statistics_checker import fes_pkg::*; #(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_value_a,
   input  logic signed [VAL_W-1:0] req_value_b,
   input  logic                    req_last_element,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [VAL_W-1:0]        rsp_element_error,
   input  logic                    rsp_field_done,
   input  logic [VAL_W-1:0]        rsp_min_relative,
   input  logic [VAL_W-1:0]        rsp_max_relative,
   input  logic [IDX_W-1:0]        rsp_max_relative_index,
   input  logic [VAL_W-1:0]        rsp_min_absolute,
   input  logic [VAL_W-1:0]        rsp_max_absolute,
   input  logic [IDX_W-1:0]        rsp_max_absolute_index,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [VAL_W-1:0]        csr_data,
   output int                      failures,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Element index saturates at the smaller of MAX_POINTS-1 and the index range
   localparam longint INDEX_LIMIT = 2 ** IDX_W - 1;
   localparam longint COUNT_CAP   = (longint'(MAX_POINTS) - 1 < INDEX_LIMIT) ?
                                    longint'(MAX_POINTS) - 1 : INDEX_LIMIT;

   typedef struct {
      logic [VAL_W-1:0] element_error;
      logic             field_done;
      logic [VAL_W-1:0] min_relative;
      logic [VAL_W-1:0] max_relative;
      logic [IDX_W-1:0] max_relative_index;
      logic [VAL_W-1:0] min_absolute;
      logic [VAL_W-1:0] max_absolute;
      logic [IDX_W-1:0] max_absolute_index;
   } field_result_type;

   // Shadow of the configuration registers
   logic [THR_W-1:0] threshold;
   logic             output_abs;

   // Running statistics of the current field
   longint           element_count;
   logic [VAL_W-1:0] low_rel;
   logic [VAL_W-1:0] high_rel;
   logic [IDX_W-1:0] high_rel_idx;
   logic [VAL_W-1:0] low_abs;
   logic [VAL_W-1:0] high_abs;
   logic [IDX_W-1:0] high_abs_idx;

   field_result_type awaited_errors[$];
   int               mismatches = 0;

   assign failures = mismatches;

   function automatic void clear_statistics();
      element_count = 0;
      low_rel       = '0;
      high_rel      = '0;
      high_rel_idx  = '0;
      low_abs       = '0;
      high_abs      = '0;
      high_abs_idx  = '0;
   endfunction

   // Errors of one pair, folded into the field statistics
   function automatic field_result_type predict_pair_errors(logic signed [VAL_W-1:0] a,
                                                            logic signed [VAL_W-1:0] b,
                                                            logic last);
      logic signed [VAL_W:0] wide_a;
      logic signed [VAL_W:0] wide_b;
      logic signed [VAL_W:0] diff;
      logic [VAL_W:0]        mag_a;
      logic [VAL_W:0]        mag_b;
      logic [VAL_W:0]        abs_wide;
      logic [VAL_W:0]        divisor;
      logic [DVD_W-1:0]      quotient;
      logic [VAL_W-1:0]      abs_err;
      logic [VAL_W-1:0]      rel_err;
      logic [IDX_W-1:0]      idx;
      field_result_type      r;
      wide_a   = a;
      wide_b   = b;
      mag_a    = (wide_a < 0) ? -wide_a : wide_a;
      mag_b    = (wide_b < 0) ? -wide_b : wide_b;
      diff     = wide_a - wide_b;
      abs_wide = (diff < 0) ? -diff : diff;
      abs_err  = abs_wide[VAL_W-1:0];
      idx      = element_count[IDX_W-1:0];

      // small magnitudes fall back to the absolute error
      if (mag_a <= {2'b00, threshold} || mag_b <= {2'b00, threshold}) begin
         rel_err = abs_err;
      end else begin
         divisor  = (mag_a > mag_b) ? mag_a : mag_b;
         quotient = {abs_err, {FRAC_W{1'b0}}} / divisor;
         rel_err  = quotient[VAL_W-1:0];
      end

      // first element seeds both extremes; later maxima keep the first index
      if (element_count == 0) begin
         low_rel      = rel_err;
         high_rel     = rel_err;
         high_rel_idx = '0;
         low_abs      = abs_err;
         high_abs     = abs_err;
         high_abs_idx = '0;
      end else begin
         if (rel_err < low_rel) low_rel = rel_err;
         if (rel_err > high_rel) begin
            high_rel     = rel_err;
            high_rel_idx = idx;
         end
         if (abs_err < low_abs) low_abs = abs_err;
         if (abs_err > high_abs) begin
            high_abs     = abs_err;
            high_abs_idx = idx;
         end
      end
      if (element_count < COUNT_CAP) element_count++;

      r = '{default: '0};
      r.element_error = output_abs ? abs_err : rel_err;
      if (last) begin
         r.field_done         = 1'b1;
         r.min_relative       = low_rel;
         r.max_relative       = high_rel;
         r.max_relative_index = high_rel_idx;
         r.min_absolute       = low_abs;
         r.max_absolute       = high_abs;
         r.max_absolute_index = high_abs_idx;
         clear_statistics();
      end
      return r;
   endfunction

   task automatic check_field(string label, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Sample every channel at the clock edge
   always @(posedge clock) begin : monitor
      field_result_type want;
      if (reset) begin
         threshold  = '0;
         output_abs = 1'b0;
         clear_statistics();
         awaited_errors.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ABS_THRESHOLD:   threshold  = csr_data[THR_W-1:0];
               CSR_OUTPUT_ABSOLUTE: output_abs = csr_data[0];
               default: ;
            endcase
         end

         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (awaited_errors.size() == 0) begin
               $display("%0t: result transfer with nothing expected, actual error %0d",
                        $time, rsp_element_error);
               mismatches++;
            end else begin
               want = awaited_errors.pop_front();
               check_field("element_error", want.element_error, rsp_element_error);
               check_field("field_done", want.field_done, rsp_field_done);
               check_field("min_relative", want.min_relative, rsp_min_relative);
               check_field("max_relative", want.max_relative, rsp_max_relative);
               check_field("max_relative_index", want.max_relative_index,
                           rsp_max_relative_index);
               check_field("min_absolute", want.min_absolute, rsp_min_absolute);
               check_field("max_absolute", want.max_absolute, rsp_max_absolute);
               check_field("max_absolute_index", want.max_absolute_index,
                           rsp_max_absolute_index);
            end
         end

         if (req_valid && req_ready)
            awaited_errors.push_back(predict_pair_errors(req_value_a, req_value_b,
                                                         req_last_element));
      end
      pending <= awaited_errors.size();
   end

endmodule

// File: tb/field_error_statistics_core_test.sv
// Stimulus and verdict for the field error statistics core.
module field_error_statistics_core_test import fes_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;
   localparam int FLUSH_CYCLES = 60;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 60;

   localparam logic signed [VAL_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] MOST_POS = 32'sh7fff_ffff;
   localparam logic signed [VAL_W-1:0] UNIT     = 32'sh0001_0000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_value_a = '0;
   logic signed [VAL_W-1:0] req_value_b = '0;
   logic                    req_last_element = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [VAL_W-1:0]        rsp_element_error;
   logic                    rsp_field_done;
   logic [VAL_W-1:0]        rsp_min_relative;
   logic [VAL_W-1:0]        rsp_max_relative;
   logic [IDX_W-1:0]        rsp_max_relative_index;
   logic [VAL_W-1:0]        rsp_min_absolute;
   logic [VAL_W-1:0]        rsp_max_absolute;
   logic [IDX_W-1:0]        rsp_max_absolute_index;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_index_type           csr_index = CSR_ABS_THRESHOLD;
   logic [VAL_W-1:0]        csr_data = '0;

   int               failures;
   int               pending;
   int               idle_odds = 4;     // 0: no idling
   int               ready_hold = 0;
   int               quiet = 0;
   logic [THR_W-1:0] cur_threshold = '0;

   always #5ns clock = ~clock;

   field_error_statistics_core uut (.*);

   field_error_statistics_checker checker_inst (.*);

   // Receiver: random stall bursts with rsp_ready low
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         ready_hold <= $urandom_range(0, 7);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("field_error_statistics_core_test: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // One pair per transfer; valid stays high between back-to-back pairs
   task automatic send_pair(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b,
                            logic last);
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_value_a      <= a;
      req_value_b      <= b;
      req_last_element <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold the sender until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type index, logic [VAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Reconfigure with the block idle; upper bits of each word are don't care
   task automatic set_config(logic [VAL_W-1:0] thr_word, logic [VAL_W-1:0] abs_word);
      drain();
      write_csr(CSR_ABS_THRESHOLD, thr_word);
      write_csr(CSR_OUTPUT_ABSOLUTE, abs_word);
      csr_valid     <= 1'b0;
      cur_threshold  = thr_word[THR_W-1:0];
   endtask

   // Sample mix: extremes, full range, small, near the threshold, mid range
   function automatic logic signed [VAL_W-1:0] pick_sample(logic [THR_W-1:0] thr);
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = 0;
               3: v = 1;
               default: v = -1;
            endcase
         end
         1, 2: v = $urandom;
         3, 4, 5: v = $urandom_range(0, 32'h0010_0000);
         6, 7: v = {1'b0, thr} + $urandom_range(0, 4) - 2;
         default: v = $urandom_range(0, 32'h0fff_ffff);
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      return v;
   endfunction

   // Second sample: equal, negated, close by, or unrelated
   function automatic logic signed [VAL_W-1:0] pick_partner(logic signed [VAL_W-1:0] a,
                                                            logic [THR_W-1:0] thr);
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = a;
         1: v = -a;
         2, 3: v = a + $urandom_range(0, 64) - 32;
         default: v = pick_sample(thr);
      endcase
      return v;
   endfunction

   initial begin : stimulus
      int                      field_left;
      int                      sent;
      logic [VAL_W-1:0]        thr_word;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
      field_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset configuration: zero threshold, relative output
      send_pair(0, 0, 1'b0);                 // zero operands fall back
      send_pair(MOST_POS, MOST_NEG, 1'b0);   // largest absolute error
      send_pair(MOST_NEG, MOST_POS, 1'b0);
      send_pair(MOST_NEG, MOST_NEG, 1'b0);
      send_pair(UNIT, -UNIT, 1'b0);          // largest relative error
      send_pair(5, 5, 1'b0);
      send_pair(UNIT, -UNIT, 1'b0);          // tie keeps the first index
      send_pair(1, -1, 1'b1);
      send_pair(100, -300, 1'b1);            // one-element field
      send_pair(-7, 3, 1'b0);
      send_pair(3, -7, 1'b1);

      // Threshold at 1.0, absolute output: boundary of the fallback
      set_config(UNIT, 1);
      send_pair(UNIT, 2 * UNIT, 1'b0);
      send_pair(UNIT + 1, 2 * UNIT, 1'b0);
      send_pair(-UNIT, -UNIT - 1, 1'b0);
      send_pair(2 * UNIT, -UNIT - 1, 1'b1);

      // Top threshold: only the most negative sample divides
      set_config(32'hffff_ffff, 32'hffff_fffe);
      send_pair(MOST_NEG, MOST_NEG, 1'b0);
      send_pair(MOST_NEG, MOST_POS, 1'b0);
      send_pair(1, 2, 1'b0);
      send_pair(MOST_NEG, -MOST_POS, 1'b1);

      // Random phases, each under its own configuration
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: thr_word = '0;
            1: thr_word = 32'hffff_ffff;
            2: thr_word = $urandom_range(0, 32'h0004_0000);
            3: thr_word = $urandom;
            4: thr_word = UNIT;
            default: thr_word = ($urandom_range(0, 1) == 1) ? $urandom :
                                $urandom_range(0, 32'h0100_0000);
         endcase
         // stretches with no idling, and none at all in the last phase
         if (phase == PHASES - 1 || phase % 3 == 2) idle_odds = 0;
         else if (phase % 3 == 0) idle_odds = 3;
         else idle_odds = 8;
         set_config(thr_word, ($urandom & ~32'h1) | (phase % 2));

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (field_left == 0)
               field_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) :
                                                          $urandom_range(1, 10);
            a = pick_sample(cur_threshold);
            b = pick_partner(a, cur_threshold);
            if ($urandom_range(0, 1) == 1) send_pair(a, b, field_left == 1);
            else send_pair(b, a, field_left == 1);
            field_left--;
            sent++;
            if (phase != PHASES - 1 && $urandom_range(0, 49) == 0) drain();
         end
      end

      // Closing: wait out every result, then a little extra
      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("field_error_statistics_core_test: done, clean");
      end else begin
         $display("field_error_statistics_core_test: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/fes_pkg.sv
hdl/fes_ctrl.sv
hdl/fes_dp.sv
hdl/field_error_statistics_core.sv
tb/field_error_statistics_checker.sv
tb/field_error_statistics_core_test.sv
